// ===== rtl/smde_pkg.sv =====
`default_nettype none

package smde_pkg;

    localparam int unsigned ROW_COUNT    = 8;
    localparam int unsigned COLUMN_COUNT = 8;

    localparam int unsigned TYPE_W = 3;
    localparam int unsigned ROW_W  = 4;
    localparam int unsigned DATA_W = 8;

    // Row store index; at least one bit even for a single row.
    localparam int unsigned ROW_IDX_W = (ROW_COUNT > 1) ? $clog2(ROW_COUNT) : 1;

    localparam logic [ROW_W:0] ROW_LIMIT = (ROW_W + 1)'(ROW_COUNT);

    localparam logic [DATA_W-1:0] COL_MASK = DATA_W'((1 << COLUMN_COUNT) - 1);

    localparam logic [TYPE_W-1:0] REQ_SCAN          = 3'd0;
    localparam logic [TYPE_W-1:0] REQ_READ_RAW      = 3'd1;
    localparam logic [TYPE_W-1:0] REQ_READ_DEB      = 3'd2;
    localparam logic [TYPE_W-1:0] REQ_TAKE_RAW_EDGE = 3'd3;
    localparam logic [TYPE_W-1:0] REQ_TAKE_DEB_EDGE = 3'd4;
    localparam logic [TYPE_W-1:0] REQ_CLEAR         = 3'd5;

    typedef logic [DATA_W-1:0] row_t;

    typedef struct packed {
        logic [TYPE_W-1:0] req_type;
        logic [ROW_W-1:0]  row_index;
        logic [DATA_W-1:0] column_bits;
    } req_t;

    typedef struct packed {
        logic [DATA_W-1:0] read_data;
        logic              row_valid;
    } rsp_t;

endpackage

`default_nettype wire

// ===== rtl/switch_matrix_debounce_edges.sv =====
// Results: an accepted transaction is registered in pend_reg and req_reg, and its result in
// done_reg and result_reg, shown on result with done high; scan and clear give none.
// Throughput: one transaction per cycle, busy stays low; the row update for each
// transaction is a single read-modify-write of the register-based row stores.
// Reset (rst_n low, asynchronous): all row stores, the edge flags and the strobes clear.
// The receiver cannot stall: each result is taken in the cycle it is shown.
`default_nettype none

module switch_matrix_debounce_edges
    import smde_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic start,
    output logic      busy,
    input  wire req_t req,
    output logic      done,
    output rsp_t      result
);

    logic pend_reg;
    req_t req_reg;

    row_t raw_reg [ROW_COUNT];
    row_t deb_reg [ROW_COUNT];
    row_t raw_edge_reg [ROW_COUNT];
    row_t deb_edge_reg [ROW_COUNT];

    row_t raw_next [ROW_COUNT];
    row_t deb_next [ROW_COUNT];
    row_t raw_edge_next [ROW_COUNT];
    row_t deb_edge_next [ROW_COUNT];

    logic done_reg;
    logic done_next;
    rsp_t result_reg;
    rsp_t result_next;

    logic                 row_ok;
    logic [ROW_IDX_W-1:0] row_idx;
    row_t                 bits;
    row_t                 moving;
    row_t                 new_deb;

    assign busy   = 1'b0;
    assign done   = done_reg;
    assign result = result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= 1'b0;
        end
        else
        begin
            pend_reg <= start;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            req_reg <= req;
        end
    end

    assign row_ok  = {1'b0, req_reg.row_index} < ROW_LIMIT;
    assign row_idx = req_reg.row_index[ROW_IDX_W-1:0];
    assign bits    = req_reg.column_bits & COL_MASK;
    assign moving  = raw_reg[row_idx] ^ bits;
    assign new_deb = (~moving & bits) | (moving & deb_reg[row_idx]);

    always_comb
    begin
        raw_next      = raw_reg;
        deb_next      = deb_reg;
        raw_edge_next = raw_edge_reg;
        deb_edge_next = deb_edge_reg;
        done_next     = 1'b0;
        result_next   = '0;

        if (pend_reg)
        begin
            unique case (req_reg.req_type)
                REQ_SCAN:
                begin
                    if (row_ok)
                    begin
                        deb_edge_next[row_idx] = deb_edge_reg[row_idx]
                                               | (new_deb & ~deb_reg[row_idx]);
                        deb_next[row_idx]      = new_deb;
                        raw_edge_next[row_idx] = raw_edge_reg[row_idx]
                                               | (bits & ~raw_reg[row_idx]);
                        raw_next[row_idx]      = bits;
                    end
                end
                REQ_READ_RAW:
                begin
                    done_next             = 1'b1;
                    result_next.row_valid = row_ok;
                    if (row_ok)
                    begin
                        result_next.read_data = raw_reg[row_idx] & bits;
                    end
                end
                REQ_READ_DEB:
                begin
                    done_next             = 1'b1;
                    result_next.row_valid = row_ok;
                    if (row_ok)
                    begin
                        result_next.read_data = deb_reg[row_idx] & bits;
                    end
                end
                REQ_TAKE_RAW_EDGE:
                begin
                    done_next             = 1'b1;
                    result_next.row_valid = row_ok;
                    if (row_ok)
                    begin
                        result_next.read_data  = raw_edge_reg[row_idx] & bits;
                        raw_edge_next[row_idx] = raw_edge_reg[row_idx] & ~bits;
                    end
                end
                REQ_TAKE_DEB_EDGE:
                begin
                    done_next             = 1'b1;
                    result_next.row_valid = row_ok;
                    if (row_ok)
                    begin
                        result_next.read_data  = deb_edge_reg[row_idx] & bits;
                        deb_edge_next[row_idx] = deb_edge_reg[row_idx] & ~bits;
                    end
                end
                REQ_CLEAR:
                begin
                    for (int i = 0; i < ROW_COUNT; i++)
                    begin
                        raw_next[i]      = '0;
                        deb_next[i]      = '0;
                        raw_edge_next[i] = '0;
                        deb_edge_next[i] = '0;
                    end
                end
                default:
                begin
                    // drop unused request codes
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
            for (int i = 0; i < ROW_COUNT; i++)
            begin
                raw_reg[i]      <= '0;
                deb_reg[i]      <= '0;
                raw_edge_reg[i] <= '0;
                deb_edge_reg[i] <= '0;
            end
        end
        else
        begin
            done_reg     <= done_next;
            raw_reg      <= raw_next;
            deb_reg      <= deb_next;
            raw_edge_reg <= raw_edge_next;
            deb_edge_reg <= deb_edge_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(pend_reg))
        else $error("result strobe without a pending transaction");

    assert property (@(posedge clk) disable iff (!rst_n)
        (done && !result.row_valid) |-> (result.read_data == '0))
        else $error("out-of-range row returned nonzero data");

    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ((result.read_data & ~COL_MASK) == '0))
        else $error("result data in unused columns");

    assert property (@(posedge clk) disable iff (!rst_n)
        (pend_reg && row_ok && req_reg.req_type == REQ_TAKE_RAW_EDGE)
        |=> ((raw_edge_reg[$past(row_idx)] & $past(bits)) == '0))
        else $error("raw edge flags not cleared after take");

    assert property (@(posedge clk) disable iff (!rst_n)
        (pend_reg && req_reg.req_type == REQ_CLEAR)
        |=> (raw_reg[0] == '0 && deb_edge_reg[0] == '0 && !done))
        else $error("clear left state or produced a result");

endmodule

`default_nettype wire

// ===== tb/sv/switch_matrix_debounce_edges_tb.sv =====
`default_nettype none

module switch_matrix_debounce_edges_tb;
    import smde_pkg::*;

    // Request codes the block leaves unused
    localparam logic [TYPE_W-1:0] REQ_SPARE_LO = 3'd6;
    localparam logic [TYPE_W-1:0] REQ_SPARE_HI = 3'd7;

    localparam int IDLE_PCT     = 17;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 6;

    localparam logic [ROW_W-1:0] FIRST_ROW = '0;
    localparam logic [ROW_W-1:0] LAST_ROW  = ROW_W'(ROW_COUNT - 1);
    localparam logic [ROW_W-1:0] OVER_ROW  = ROW_W'(ROW_COUNT);
    localparam logic [ROW_W-1:0] TOP_ROW   = '1;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    req_t req   = '0;
    logic busy;
    logic done;
    rsp_t result;

    row_t raw_level       [ROW_COUNT] = '{default: '0};
    row_t debounced_level [ROW_COUNT] = '{default: '0};
    row_t raw_rise        [ROW_COUNT] = '{default: '0};
    row_t debounced_rise  [ROW_COUNT] = '{default: '0};

    rsp_t pending_readbacks [$];
    int   error_count  = 0;
    int   quiet_cycles = 0;
    bit   steady_drive = 1'b0;

    switch_matrix_debounce_edges dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .req    (req),
        .done   (done),
        .result (result)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Update the switch store for one transaction; return 1 when it yields a readback.
    function automatic bit apply_switch_request(input req_t r, output rsp_t readback);
        row_t                 bits;
        logic [ROW_IDX_W-1:0] idx;
        bit                   in_range;
        row_t                 moving;
        row_t                 new_deb;
        bits     = r.column_bits & COL_MASK;
        in_range = r.row_index < ROW_COUNT;
        idx      = r.row_index[ROW_IDX_W-1:0];
        readback = '0;
        readback.row_valid = in_range;
        case (r.req_type)
            REQ_SCAN:
            begin
                if (in_range)
                begin
                    // a column follows the sample only when two samples agree
                    moving  = raw_level[idx] ^ bits;
                    new_deb = (~moving & bits) | (moving & debounced_level[idx]);
                    debounced_rise[idx]  |= new_deb & ~debounced_level[idx];
                    debounced_level[idx]  = new_deb;
                    raw_rise[idx]        |= bits & ~raw_level[idx];
                    raw_level[idx]        = bits;
                end
                return 1'b0;
            end
            REQ_CLEAR:
            begin
                foreach (raw_level[i])
                begin
                    raw_level[i]       = '0;
                    debounced_level[i] = '0;
                    raw_rise[i]        = '0;
                    debounced_rise[i]  = '0;
                end
                return 1'b0;
            end
            REQ_READ_RAW:
            begin
                if (in_range)
                    readback.read_data = raw_level[idx] & bits;
            end
            REQ_READ_DEB:
            begin
                if (in_range)
                    readback.read_data = debounced_level[idx] & bits;
            end
            REQ_TAKE_RAW_EDGE:
            begin
                if (in_range)
                begin
                    readback.read_data = raw_rise[idx] & bits;
                    raw_rise[idx] &= ~bits;
                end
            end
            REQ_TAKE_DEB_EDGE:
            begin
                if (in_range)
                begin
                    readback.read_data = debounced_rise[idx] & bits;
                    debounced_rise[idx] &= ~bits;
                end
            end
            default:
                return 1'b0;
        endcase
        return 1'b1;
    endfunction

    function automatic req_t pack_req(input logic [TYPE_W-1:0] kind,
                                      input logic [ROW_W-1:0] row, input row_t bits);
        req_t r;
        r.req_type    = kind;
        r.row_index   = row;
        r.column_bits = bits;
        return r;
    endfunction

    // Check results against the oldest readback, then record the accepted transaction.
    always @(posedge clk)
    begin : track
        rsp_t wanted;
        if (rst_n && done)
        begin
            if (pending_readbacks.size() == 0)
            begin
                $display("%0t: result with none pending: read_data=%02h row_valid=%0b",
                         $time, result.read_data, result.row_valid);
                error_count++;
            end
            else
            begin
                wanted = pending_readbacks.pop_front();
                if (result.read_data !== wanted.read_data)
                begin
                    $display("%0t: read_data mismatch: expected %02h actual %02h",
                             $time, wanted.read_data, result.read_data);
                    error_count++;
                end
                if (result.row_valid !== wanted.row_valid)
                begin
                    $display("%0t: row_valid mismatch: expected %0b actual %0b",
                             $time, wanted.row_valid, result.row_valid);
                    error_count++;
                end
            end
        end
        if (rst_n && start && !busy)
        begin
            if (apply_switch_request(req, wanted))
                pending_readbacks.push_back(wanted);
        end
    end

    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic send_item(input req_t item);
        @(negedge clk);
        while (!steady_drive && $urandom_range(99) < IDLE_PCT)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
        start <= 1'b1;
        req   <= item;
        @(posedge clk);
        while (busy !== 1'b0)
            @(posedge clk);
    endtask

    task automatic test_directed();
        send_item(pack_req(REQ_READ_RAW, FIRST_ROW, '1));
        send_item(pack_req(REQ_SCAN, FIRST_ROW, '1));
        send_item(pack_req(REQ_READ_DEB, FIRST_ROW, '1));
        send_item(pack_req(REQ_SCAN, FIRST_ROW, '1));
        send_item(pack_req(REQ_READ_DEB, FIRST_ROW, '1));
        // partial take leaves the unmasked flags set
        send_item(pack_req(REQ_TAKE_RAW_EDGE, FIRST_ROW, 8'h0F));
        send_item(pack_req(REQ_TAKE_RAW_EDGE, FIRST_ROW, '1));
        send_item(pack_req(REQ_TAKE_DEB_EDGE, FIRST_ROW, '0));
        send_item(pack_req(REQ_TAKE_DEB_EDGE, FIRST_ROW, '1));
        // bouncing row: debounced value must hold
        send_item(pack_req(REQ_SCAN, LAST_ROW, 8'hA5));
        send_item(pack_req(REQ_SCAN, LAST_ROW, 8'h5A));
        send_item(pack_req(REQ_READ_RAW, LAST_ROW, '1));
        send_item(pack_req(REQ_READ_DEB, LAST_ROW, '1));
        send_item(pack_req(REQ_SCAN, OVER_ROW, '1));
        send_item(pack_req(REQ_READ_RAW, TOP_ROW, '1));
        send_item(pack_req(REQ_TAKE_DEB_EDGE, OVER_ROW, '1));
        send_item(pack_req(REQ_SPARE_LO, FIRST_ROW, '1));
        send_item(pack_req(REQ_SPARE_HI, TOP_ROW, '1));
        send_item(pack_req(REQ_CLEAR, FIRST_ROW, '1));
        send_item(pack_req(REQ_READ_DEB, FIRST_ROW, '1));
        send_item(pack_req(REQ_TAKE_RAW_EDGE, LAST_ROW, '1));
        send_item(pack_req(REQ_READ_RAW, LAST_ROW, 8'h80));
        send_item(pack_req(REQ_SCAN, FIRST_ROW, '0));
        send_item(pack_req(REQ_READ_DEB, FIRST_ROW, '1));
    endtask

    // Scan bursts on one row with settling or bouncing columns, then queries on that row.
    task automatic test_debounce_sequences(input int item_goal);
        int                sent;
        logic [ROW_W-1:0]  row;
        row_t              sample;
        row_t              mask;
        logic [TYPE_W-1:0] kind;
        sent = 0;
        while (sent < item_goal)
        begin
            steady_drive = (sent >= item_goal / 3) && (sent < item_goal / 2);
            if ($urandom_range(9) == 0)
                row = ROW_W'($urandom_range(15));
            else
                row = ROW_W'($urandom_range(ROW_COUNT - 1));
            sample = row_t'($urandom);
            repeat ($urandom_range(4, 1))
            begin
                if ($urandom_range(99) < 40)
                    sample ^= row_t'(1 << $urandom_range(DATA_W - 1));
                else if ($urandom_range(99) < 10)
                    sample = row_t'($urandom);
                send_item(pack_req(REQ_SCAN, row, sample));
                sent++;
            end
            repeat ($urandom_range(2, 1))
            begin
                kind = TYPE_W'(REQ_READ_RAW + $urandom_range(3));
                mask = $urandom_range(1) ? '1 : row_t'($urandom);
                send_item(pack_req(kind, row, mask));
                sent++;
            end
        end
        steady_drive = 1'b0;
    endtask

    // Unstructured traffic: any code, any row, any bits; clears kept rare.
    task automatic test_mixed_noise(input int item_goal);
        int                sent;
        logic [TYPE_W-1:0] kind;
        sent = 0;
        while (sent < item_goal)
        begin
            kind = TYPE_W'($urandom_range(7));
            if (kind == REQ_CLEAR && $urandom_range(9) != 0)
                kind = REQ_READ_DEB;
            send_item(pack_req(kind, ROW_W'($urandom_range(15)), row_t'($urandom)));
            sent++;
        end
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_directed();
        test_debounce_sequences(330);
        test_mixed_noise(100);
        @(negedge clk);
        start <= 1'b0;
        while (pending_readbacks.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

`default_nettype wire
